// ===== rtl/oai_pkg.sv =====
package oai_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_POP    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_READ   = 3'd4,
    MODE_FIND   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_PUT,
    S_INS_CHK,
    S_INS_WR,
    S_FETCH,
    S_GRAB,
    S_REM_CHK,
    S_REM_WR,
    S_SCAN,
    S_SCAN_CMP,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_LOAD_CNT,
    PTR_LOAD_CNT_M1,
    PTR_LOAD_IDX,
    PTR_LOAD_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_e;

  typedef enum logic {
    WR_VAL,
    WR_RD
  } wr_src_e;

  typedef struct packed {
    logic    load;
    ptr_op_e ptr_op;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_src_e wr_src;
    logic    cap_data;
    logic    set_found;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  ok;
    logic  ptr_eq_idx;
    logic  ptr_eq_cnt;
    logic  ptr_next_eq_cnt;
    logic  match;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ordered_array_insert_remove.sv =====
// One command at a time: the block is ready again as the result goes valid, and an
// untaken result holds the next one in DONE. Insert and remove shift the store one
// entry at a time, and find scans it entry by entry.
// Reset (rst_ni low, asynchronous) empties the array and drops any pending result.
module ordered_array_insert_remove (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         mode_i,
  input  logic [oai_pkg::CNT_W-1:0]          index_i,
  input  logic signed [oai_pkg::WORD_W-1:0]  value_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [oai_pkg::WORD_W-1:0]  data_o,
  output logic [oai_pkg::ADDR_W-1:0]         position_o,
  output logic                               found_o,
  output logic [1:0]                         status_o,
  output logic [oai_pkg::CNT_W-1:0]          count_o,
  output logic                               empty_o
);

  // The sequencer drives the datapath through this command word, one step per cycle while
  // not held in DONE, and watches pointer compares, the find match and result-slot space.
  oai_pkg::dp_cmd_t  cmd;
  oai_pkg::dp_stat_t stat;

  // Sequencer: takes a beat only when idle, then walks the store entry by
  // entry for insert, remove and find; a finished result waits in DONE until
  // the output register frees up.
  oai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: store memory, element count, walk pointer, command latch and
  // the result register that holds a beat until the consumer takes it.
  oai_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .data_o      (data_o),
    .position_o  (position_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .empty_o     (empty_o)
  );

endmodule

// ===== rtl/oai_dp.sv =====
module oai_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oai_pkg::dp_cmd_t                   cmd_i,
  output oai_pkg::dp_stat_t                  stat_o,
  input  logic [2:0]                         mode_i,
  input  logic [oai_pkg::CNT_W-1:0]          index_i,
  input  logic signed [oai_pkg::WORD_W-1:0]  value_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic signed [oai_pkg::WORD_W-1:0]  data_o,
  output logic [oai_pkg::ADDR_W-1:0]         position_o,
  output logic                               found_o,
  output logic [1:0]                         status_o,
  output logic [oai_pkg::CNT_W-1:0]          count_o,
  output logic                               empty_o
);

  logic [oai_pkg::WORD_W-1:0] mem [oai_pkg::DEPTH];

  oai_pkg::mode_e             mode_q;
  oai_pkg::status_e           status_q, status_d;
  logic [oai_pkg::CNT_W-1:0]  idx_q;
  logic [oai_pkg::WORD_W-1:0] val_q;
  logic [oai_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [oai_pkg::CNT_W-1:0]  ptr_q, ptr_d;
  logic [oai_pkg::CNT_W-1:0]  ptr_m1, ptr_p1;
  logic [oai_pkg::WORD_W-1:0] rd_q;
  logic [oai_pkg::WORD_W-1:0] data_q;
  logic [oai_pkg::ADDR_W-1:0] pos_q;
  logic                       found_q;
  logic [oai_pkg::ADDR_W-1:0] raddr;
  logic [oai_pkg::WORD_W-1:0] wdata;
  logic                       full;

  logic                       out_valid_q;
  logic [oai_pkg::WORD_W-1:0] res_data_q;
  logic [oai_pkg::ADDR_W-1:0] res_pos_q;
  logic                       res_found_q;
  oai_pkg::status_e           res_status_q;
  logic [oai_pkg::CNT_W-1:0]  res_count_q;

  assign full   = (cnt_q >= oai_pkg::CNT_W'(oai_pkg::DEPTH));
  assign ptr_m1 = ptr_q - oai_pkg::CNT_W'(1);
  assign ptr_p1 = ptr_q + oai_pkg::CNT_W'(1);

  // Check the command against the count at the beat that brings it in.
  always_comb begin
    status_d = oai_pkg::ST_OK;
    case (oai_pkg::mode_e'(mode_i))
      oai_pkg::MODE_APPEND: begin
        if (full) status_d = oai_pkg::ST_FULL;
      end
      oai_pkg::MODE_INSERT: begin
        if (index_i > cnt_q)  status_d = oai_pkg::ST_RANGE;
        else if (full)        status_d = oai_pkg::ST_FULL;
      end
      oai_pkg::MODE_POP: begin
        if (cnt_q == '0) status_d = oai_pkg::ST_EMPTY;
      end
      oai_pkg::MODE_REMOVE, oai_pkg::MODE_READ: begin
        if (index_i >= cnt_q) status_d = oai_pkg::ST_RANGE;
      end
      default: status_d = oai_pkg::ST_OK;
    endcase
  end

  always_comb begin
    case (cmd_i.ptr_op)
      oai_pkg::PTR_LOAD_CNT:    ptr_d = cnt_q;
      oai_pkg::PTR_LOAD_CNT_M1: ptr_d = cnt_q - oai_pkg::CNT_W'(1);
      oai_pkg::PTR_LOAD_IDX:    ptr_d = idx_q;
      oai_pkg::PTR_LOAD_ZERO:   ptr_d = '0;
      oai_pkg::PTR_INC:         ptr_d = ptr_p1;
      oai_pkg::PTR_DEC:         ptr_d = ptr_m1;
      default:                  ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      oai_pkg::RD_PTR_M1: raddr = ptr_m1[oai_pkg::ADDR_W-1:0];
      oai_pkg::RD_PTR_P1: raddr = ptr_p1[oai_pkg::ADDR_W-1:0];
      default:            raddr = ptr_q[oai_pkg::ADDR_W-1:0];
    endcase
  end

  assign wdata = (cmd_i.wr_src == oai_pkg::WR_RD) ? rd_q : val_q;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc)      cnt_d = cnt_q + oai_pkg::CNT_W'(1);
    else if (cmd_i.cnt_dec) cnt_d = cnt_q - oai_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[ptr_q[oai_pkg::ADDR_W-1:0]] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      if (cmd_i.res_load)   out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= oai_pkg::mode_e'(mode_i);
      idx_q    <= index_i;
      val_q    <= value_i;
      status_q <= status_d;
      data_q   <= '0;
      pos_q    <= '0;
      found_q  <= 1'b0;
    end else begin
      if (cmd_i.cap_data) data_q <= rd_q;
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
        pos_q   <= ptr_q[oai_pkg::ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_data_q   <= data_q;
      res_pos_q    <= pos_q;
      res_found_q  <= found_q;
      res_status_q <= status_q;
      res_count_q  <= cnt_q;
    end
  end

  assign stat_o.mode            = mode_q;
  assign stat_o.ok              = (status_q == oai_pkg::ST_OK);
  assign stat_o.ptr_eq_idx      = (ptr_q == idx_q);
  assign stat_o.ptr_eq_cnt      = (ptr_q == cnt_q);
  assign stat_o.ptr_next_eq_cnt = (ptr_p1 == cnt_q);
  assign stat_o.match           = (rd_q == val_q);
  assign stat_o.out_free        = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign data_o      = res_data_q;
  assign position_o  = res_pos_q;
  assign found_o     = res_found_q;
  assign status_o    = res_status_q;
  assign count_o     = res_count_q;
  assign empty_o     = (res_count_q == '0);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= oai_pkg::CNT_W'(oai_pkg::DEPTH))
    else $error("element count above capacity");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> !full)
    else $error("count raised on a full array");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0)
    else $error("count lowered on an empty array");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> ptr_q < oai_pkg::CNT_W'(oai_pkg::DEPTH))
    else $error("store write beyond capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/oai_ctrl.sv =====
module oai_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  oai_pkg::dp_stat_t stat_i,
  output oai_pkg::dp_cmd_t  cmd_o
);

  oai_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oai_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      oai_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = oai_pkg::S_DISPATCH;
        end
      end
      oai_pkg::S_DISPATCH: begin
        if (!stat_i.ok) begin
          state_d = oai_pkg::S_DONE;
        end else begin
          case (stat_i.mode)
            oai_pkg::MODE_APPEND: begin
              cmd_o.ptr_op = oai_pkg::PTR_LOAD_CNT;
              state_d      = oai_pkg::S_PUT;
            end
            oai_pkg::MODE_INSERT: begin
              cmd_o.ptr_op = oai_pkg::PTR_LOAD_CNT;
              state_d      = oai_pkg::S_INS_CHK;
            end
            oai_pkg::MODE_POP: begin
              cmd_o.ptr_op = oai_pkg::PTR_LOAD_CNT_M1;
              state_d      = oai_pkg::S_FETCH;
            end
            oai_pkg::MODE_REMOVE, oai_pkg::MODE_READ: begin
              cmd_o.ptr_op = oai_pkg::PTR_LOAD_IDX;
              state_d      = oai_pkg::S_FETCH;
            end
            oai_pkg::MODE_FIND: begin
              cmd_o.ptr_op = oai_pkg::PTR_LOAD_ZERO;
              state_d      = oai_pkg::S_SCAN;
            end
            default: state_d = oai_pkg::S_DONE;
          endcase
        end
      end
      oai_pkg::S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_src  = oai_pkg::WR_VAL;
        cmd_o.cnt_inc = 1'b1;
        state_d       = oai_pkg::S_DONE;
      end
      oai_pkg::S_INS_CHK: begin
        if (stat_i.ptr_eq_idx) begin
          state_d = oai_pkg::S_PUT;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = oai_pkg::RD_PTR_M1;
          state_d      = oai_pkg::S_INS_WR;
        end
      end
      oai_pkg::S_INS_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = oai_pkg::WR_RD;
        cmd_o.ptr_op = oai_pkg::PTR_DEC;
        state_d      = oai_pkg::S_INS_CHK;
      end
      oai_pkg::S_FETCH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = oai_pkg::RD_PTR;
        state_d      = oai_pkg::S_GRAB;
      end
      oai_pkg::S_GRAB: begin
        cmd_o.cap_data = 1'b1;
        case (stat_i.mode)
          oai_pkg::MODE_POP: begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = oai_pkg::S_DONE;
          end
          oai_pkg::MODE_REMOVE: state_d = oai_pkg::S_REM_CHK;
          default:              state_d = oai_pkg::S_DONE;
        endcase
      end
      oai_pkg::S_REM_CHK: begin
        if (stat_i.ptr_next_eq_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = oai_pkg::S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = oai_pkg::RD_PTR_P1;
          state_d      = oai_pkg::S_REM_WR;
        end
      end
      oai_pkg::S_REM_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = oai_pkg::WR_RD;
        cmd_o.ptr_op = oai_pkg::PTR_INC;
        state_d      = oai_pkg::S_REM_CHK;
      end
      oai_pkg::S_SCAN: begin
        if (stat_i.ptr_eq_cnt) begin
          state_d = oai_pkg::S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = oai_pkg::RD_PTR;
          state_d      = oai_pkg::S_SCAN_CMP;
        end
      end
      oai_pkg::S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.set_found = 1'b1;
          state_d         = oai_pkg::S_DONE;
        end else begin
          cmd_o.ptr_op = oai_pkg::PTR_INC;
          state_d      = oai_pkg::S_SCAN;
        end
      end
      oai_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = oai_pkg::S_IDLE;
        end
      end
      default: state_d = oai_pkg::S_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == oai_pkg::S_DISPATCH)
    else $error("command taken outside idle");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.rd_en && cmd_o.wr_en))
    else $error("read and write issued in one cycle");

  a_result_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> state_q == oai_pkg::S_IDLE)
    else $error("result loaded without return to idle");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

// Command/result bench for the ordered array engine. A shadow copy of the
// array predicts every result but those typed into the table. The directed table covers the edge cases, a
// biased random phase fills, churns and drains the array, and both channels
// see random idle cycles.
module tb;

  localparam int unsigned DEPTH  = oai_pkg::DEPTH;
  localparam int unsigned WORD_W = oai_pkg::WORD_W;
  localparam int unsigned CNT_W  = oai_pkg::CNT_W;
  localparam int unsigned ADDR_W = oai_pkg::ADDR_W;

  localparam realtime CLK_PERIOD = 12.0;
  localparam int      RST_CYC    = 6;
  localparam int      IDLE_PCT   = 14;
  localparam int      RAND_ITEMS = 1230;
  localparam int      BIAS_SPAN  = 80;     // commands between bias draws
  localparam int      HOLD_CYC   = 400;    // long result-side hold-off
  // worst single command: a find with no match over a full array
  localparam int      DRAIN_CYC  = 4 + 2 * DEPTH + 20;
  localparam realtime LIMIT_NS   = 800_000 * CLK_PERIOD;
  localparam int      MAX_SHOWN  = 10;

  // One command beat.
  typedef struct packed {
    oai_pkg::mode_e            mode;
    logic [CNT_W-1:0]          index;
    logic signed [WORD_W-1:0]  value;
  } array_cmd_t;

  // One result beat.
  typedef struct packed {
    logic signed [WORD_W-1:0]  data;
    logic [ADDR_W-1:0]         position;
    logic                      found;
    oai_pkg::status_e          status;
    logic [CNT_W-1:0]          count;
    logic                      empty;
  } array_result_t;

  // Row of the directed table. A typed row carries its result inline,
  // every other row is checked against the shadow array.
  typedef struct packed {
    array_cmd_t    cmd;
    logic          typed;
    array_result_t res;
  } stim_row_t;

  typedef enum logic [1:0] {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_CHURN
  } bias_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [2:0]                 mode_i;
  logic [CNT_W-1:0]           index_i;
  logic signed [WORD_W-1:0]   value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [WORD_W-1:0]   data_o;
  logic [ADDR_W-1:0]          position_o;
  logic                       found_o;
  logic [1:0]                 status_o;
  logic [CNT_W-1:0]           count_o;
  logic                       empty_o;

  // Shadow of the block's state, advanced on every accepted command.
  logic signed [WORD_W-1:0]   shadow_store [DEPTH];
  int                         shadow_count;

  array_result_t              pending_results [$];
  stim_row_t                  directed_rows [$];

  // Handshake between the stimulus thread and the result-side driver.
  bit                         quiet;      // no idle cycles on either side
  bit                         hold_req;   // asks the result side for its long hold-off

  int                         fail_cnt;
  int                         results_seen;
  int                         mode_cnt [6];
  int                         full_refused;
  int                         range_refused;
  int                         empty_refused;
  int                         finds_matched;
  int                         peak_count;

  ordered_array_insert_remove u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .position_o  (position_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .empty_o     (empty_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Apply one command to the shadow array and return the result it gives.
  // Refused commands leave the shadow untouched.
  function automatic array_result_t predict_array_op(array_cmd_t c);
    array_result_t r;
    int            n;
    int            i;
    r        = '0;
    r.status = oai_pkg::ST_OK;
    n        = shadow_count;
    case (c.mode)
      oai_pkg::MODE_APPEND: begin
        if (n >= DEPTH) begin
          r.status = oai_pkg::ST_FULL;
        end else begin
          shadow_store[n] = c.value;
          shadow_count    = n + 1;
        end
      end
      oai_pkg::MODE_INSERT: begin
        // the index check wins over the full check
        if (c.index > n) begin
          r.status = oai_pkg::ST_RANGE;
        end else if (n >= DEPTH) begin
          r.status = oai_pkg::ST_FULL;
        end else begin
          for (i = n; i > c.index; i--) shadow_store[i] = shadow_store[i - 1];
          shadow_store[c.index] = c.value;
          shadow_count          = n + 1;
        end
      end
      oai_pkg::MODE_POP: begin
        if (n == 0) begin
          r.status = oai_pkg::ST_EMPTY;
        end else begin
          r.data       = shadow_store[n - 1];
          shadow_count = n - 1;
        end
      end
      oai_pkg::MODE_REMOVE: begin
        if (c.index >= n) begin
          r.status = oai_pkg::ST_RANGE;
        end else begin
          r.data = shadow_store[c.index];
          for (i = c.index; i + 1 < n; i++) shadow_store[i] = shadow_store[i + 1];
          shadow_count = n - 1;
        end
      end
      oai_pkg::MODE_READ: begin
        if (c.index >= n) r.status = oai_pkg::ST_RANGE;
        else r.data = shadow_store[c.index];
      end
      oai_pkg::MODE_FIND: begin
        // lowest matching position wins; no match is still ok
        for (i = 0; i < n; i++) begin
          if (shadow_store[i] == c.value) begin
            r.position = ADDR_W'(i);
            r.found    = 1'b1;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic stim_row_t row(oai_pkg::mode_e m, int idx,
                                    logic signed [WORD_W-1:0] v);
    stim_row_t s;
    s           = '0;
    s.cmd.mode  = m;
    s.cmd.index = CNT_W'(idx);
    s.cmd.value = v;
    return s;
  endfunction

  // Row with its result typed in: only status, data and count vary here,
  // position and found stay zero and the empty flag follows the count.
  function automatic stim_row_t row_exp(oai_pkg::mode_e m, int idx,
                                        logic signed [WORD_W-1:0] v,
                                        oai_pkg::status_e st,
                                        logic signed [WORD_W-1:0] d, int cnt);
    stim_row_t s;
    s            = row(m, idx, v);
    s.typed      = 1'b1;
    s.res.data   = d;
    s.res.status = st;
    s.res.count  = CNT_W'(cnt);
    s.res.empty  = (cnt == 0);
    return s;
  endfunction

  function automatic void add_row(stim_row_t s);
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  // Draw one random command, steered by the current bias. Most indices are
  // legal for the current count; the rest span 0 to DEPTH.
  function automatic array_cmd_t random_cmd(bias_e b);
    array_cmd_t c;
    int         n;
    int         p;
    n = shadow_count;
    p = $urandom_range(99);
    case (b)
      BIAS_FILL: begin
        c.mode = p < 50 ? oai_pkg::MODE_APPEND : p < 75 ? oai_pkg::MODE_INSERT :
                 p < 85 ? oai_pkg::MODE_FIND   : p < 93 ? oai_pkg::MODE_READ   :
                 p < 97 ? oai_pkg::MODE_REMOVE : oai_pkg::MODE_POP;
      end
      BIAS_DRAIN: begin
        c.mode = p < 30 ? oai_pkg::MODE_POP  : p < 60 ? oai_pkg::MODE_REMOVE :
                 p < 75 ? oai_pkg::MODE_READ : p < 88 ? oai_pkg::MODE_FIND   :
                 p < 94 ? oai_pkg::MODE_APPEND : oai_pkg::MODE_INSERT;
      end
      default: begin
        c.mode = oai_pkg::mode_e'($urandom_range(oai_pkg::MODE_FIND));
      end
    endcase

    if ($urandom_range(99) < 15)             c.index = CNT_W'($urandom_range(DEPTH));
    else if (c.mode == oai_pkg::MODE_INSERT) c.index = CNT_W'($urandom_range(n));
    else if (n == 0)                         c.index = '0;
    else                                     c.index = CNT_W'($urandom_range(n - 1));

    // Reuse stored words often so finds hit and duplicates pile up.
    p = $urandom_range(99);
    if (n > 0 && (p < 25 || (c.mode == oai_pkg::MODE_FIND && p < 75))) begin
      c.value = shadow_store[$urandom_range(n - 1)];
    end else if (p < 85) begin
      c.value = $urandom;
    end else begin
      case ($urandom_range(3))
        0:       c.value = 32'sh8000_0000;
        1:       c.value = 32'sh7fff_ffff;
        2:       c.value = '0;
        default: c.value = -1;
      endcase
    end
    return c;
  endfunction

  function automatic void note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_SHOWN) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Offer one command beat and hold it until accepted. Valid stays high
  // across back-to-back beats; it drops only for idle cycles, in settle and after the last beat.
  task automatic offer(stim_row_t s);
    array_result_t want;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= s.cmd.mode;
    index_i    <= s.cmd.index;
    value_i    <= s.cmd.value;
    do @(posedge clk_i); while (!in_ready_o);

    want = predict_array_op(s.cmd);
    if (s.typed) want = s.res;
    pending_results.insert(pending_results.size(), want);

    mode_cnt[s.cmd.mode]++;
    if (want.status == oai_pkg::ST_FULL)  full_refused++;
    if (want.status == oai_pkg::ST_RANGE) range_refused++;
    if (want.status == oai_pkg::ST_EMPTY) empty_refused++;
    if (want.found)                       finds_matched++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // Drop valid and wait until every outstanding result has been returned.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result-side driver: random back-pressure, a quiet stretch, and one
  // long hold-off on request so the block backs up into the command side.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker: every accepted beat is matched against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    array_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result: data=%h status=%0d count=%0d",
                            data_o, status_o, count_o));
      end else begin
        want = pending_results.pop_front();
        if (data_o !== want.data || position_o !== want.position ||
            found_o !== want.found || status_o !== want.status ||
            count_o !== want.count || empty_o !== want.empty) begin
          note_fail($sformatf({"result %0d mismatch: exp data=%h pos=%0d found=%0b ",
                               "st=%0d cnt=%0d empty=%0b | got data=%h pos=%0d found=%0b ",
                               "st=%0d cnt=%0d empty=%0b"},
                              results_seen, want.data, want.position, want.found,
                              want.status, want.count, want.empty, data_o, position_o,
                              found_o, status_o, count_o, empty_o));
        end
      end
    end
  end

  // Hang guard.
  initial begin
    #(LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t s;
    bias_e     bias;
    int        k;

    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    in_valid_i <= 1'b0;
    mode_i     <= oai_pkg::MODE_APPEND;
    index_i    <= '0;
    value_i    <= '0;
    bias       = BIAS_FILL;

    // Directed table: empty-array commands first, then build a short list
    // from the extreme words and poke at it from both ends.
    add_row(row_exp(oai_pkg::MODE_POP,    0, '0, oai_pkg::ST_EMPTY, '0, 0));
    add_row(row_exp(oai_pkg::MODE_REMOVE, 0, '0, oai_pkg::ST_RANGE, '0, 0));
    add_row(row_exp(oai_pkg::MODE_READ,   DEPTH, '0, oai_pkg::ST_RANGE, '0, 0));
    add_row(row_exp(oai_pkg::MODE_FIND,   0, '0, oai_pkg::ST_OK, '0, 0));
    add_row(row_exp(oai_pkg::MODE_INSERT, 1, 32'sd5, oai_pkg::ST_RANGE, '0, 0));
    add_row(row_exp(oai_pkg::MODE_INSERT, 0, 32'sh7fff_ffff, oai_pkg::ST_OK, '0, 1));
    add_row(row_exp(oai_pkg::MODE_APPEND, 0, 32'sh8000_0000, oai_pkg::ST_OK, '0, 2));
    add_row(row_exp(oai_pkg::MODE_APPEND, 0, -1, oai_pkg::ST_OK, '0, 3));
    // insert right at the end: index equal to count is legal
    add_row(row_exp(oai_pkg::MODE_INSERT, 3, '0, oai_pkg::ST_OK, '0, 4));
    add_row(row(oai_pkg::MODE_INSERT, 1, 32'sh5555_5555));
    add_row(row_exp(oai_pkg::MODE_INSERT, 6, 32'sd1, oai_pkg::ST_RANGE, '0, 5));
    add_row(row_exp(oai_pkg::MODE_READ,   0, '0, oai_pkg::ST_OK, 32'sh7fff_ffff, 5));
    add_row(row(oai_pkg::MODE_READ, 4, '0));
    add_row(row_exp(oai_pkg::MODE_READ,   5, '0, oai_pkg::ST_RANGE, '0, 5));
    add_row(row(oai_pkg::MODE_FIND, 0, 32'sh8000_0000));
    add_row(row(oai_pkg::MODE_FIND, 0, 32'sh2aaa_aaaa));
    // duplicate word: find must report the lower position
    add_row(row(oai_pkg::MODE_APPEND, 0, -1));
    add_row(row(oai_pkg::MODE_FIND, 0, -1));
    add_row(row(oai_pkg::MODE_REMOVE, 0, '0));
    add_row(row_exp(oai_pkg::MODE_REMOVE, DEPTH, '0, oai_pkg::ST_RANGE, '0, 5));
    add_row(row(oai_pkg::MODE_REMOVE, 4, '0));
    add_row(row(oai_pkg::MODE_POP, 0, '0));

    repeat (RST_CYC) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) offer(directed_rows[k]);
    settle();

    // Random phase. Bias is redrawn every BIAS_SPAN commands; a near-empty array
    // is pushed toward filling so the full case is reached and held.
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % BIAS_SPAN == 0) begin
        if (shadow_count < 8) bias = BIAS_FILL;
        else if (shadow_count > 56 && $urandom_range(1)) bias = BIAS_DRAIN;
        else bias = bias_e'($urandom_range(BIAS_CHURN));
      end
      quiet = (k >= 300 && k < 500);
      if (k == 650) hold_req = 1'b1;
      if (k == 900) settle();
      s     = '0;
      s.cmd = random_cmd(bias);
      offer(s);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Ran %0d commands (append %0d, insert %0d, pop %0d, remove %0d, read %0d, find %0d).",
             results_seen, mode_cnt[oai_pkg::MODE_APPEND], mode_cnt[oai_pkg::MODE_INSERT],
             mode_cnt[oai_pkg::MODE_POP], mode_cnt[oai_pkg::MODE_REMOVE],
             mode_cnt[oai_pkg::MODE_READ], mode_cnt[oai_pkg::MODE_FIND]);
    $display("Refusals: full %0d, range %0d, empty %0d; finds hit %0d; peak count %0d; errors %0d.",
             full_refused, range_refused, empty_refused, finds_matched, peak_count, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
